// File: hw/rtl/stt_pkg.sv
package stt_pkg;

    localparam int MAX_SOURCE_BYTES = 65536;
    localparam logic [15:0] POS_CAP = (MAX_SOURCE_BYTES - 1 < 65535) ?
        16'(MAX_SOURCE_BYTES - 1) : 16'hFFFF;
    localparam logic [15:0] LINE_CAP = 16'hFFFF;

    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = "#";
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_QUOTE = "\"";
    localparam logic [7:0] CH_BANG  = "!";
    localparam logic [7:0] CH_LT    = "<";
    localparam logic [7:0] CH_GT    = ">";
    localparam logic [7:0] CH_US    = "_";

    localparam logic [31:0] KW_FALSE_TAIL   = "alse";
    localparam logic [47:0] KW_INCLUDE_TAIL = "nclude";
    localparam logic [15:0] KW_NIL_TAIL     = "il";
    localparam logic [31:0] KW_PRINT_TAIL   = "rint";
    localparam logic [23:0] KW_TRUE_TAIL    = "rue";

    localparam logic [2:0] KW_NONE    = 3'd0;
    localparam logic [2:0] KW_FALSE   = 3'd1;
    localparam logic [2:0] KW_INCLUDE = 3'd2;
    localparam logic [2:0] KW_NIL     = 3'd3;
    localparam logic [2:0] KW_PRINT   = 3'd4;
    localparam logic [2:0] KW_TRUE    = 3'd5;

    localparam logic [4:0] K_END      = 5'd0;
    localparam logic [4:0] K_ERROR    = 5'd1;
    localparam logic [4:0] K_NUMBER   = 5'd2;
    localparam logic [4:0] K_IDENT    = 5'd3;
    localparam logic [4:0] K_STRING   = 5'd4;
    localparam logic [4:0] K_KW_BASE  = 5'd4;
    localparam logic [4:0] K_ASSIGN   = 5'd10;
    localparam logic [4:0] K_EQ_EQ    = 5'd11;
    localparam logic [4:0] K_SEMI     = 5'd12;
    localparam logic [4:0] K_LPAREN   = 5'd13;
    localparam logic [4:0] K_RPAREN   = 5'd14;
    localparam logic [4:0] K_DOT      = 5'd15;
    localparam logic [4:0] K_BANG     = 5'd16;
    localparam logic [4:0] K_BANG_EQ  = 5'd17;
    localparam logic [4:0] K_LT       = 5'd18;
    localparam logic [4:0] K_LT_EQ    = 5'd19;
    localparam logic [4:0] K_GT       = 5'd20;
    localparam logic [4:0] K_GT_EQ    = 5'd21;
    localparam logic [4:0] K_PLUS     = 5'd22;
    localparam logic [4:0] K_MINUS    = 5'd23;
    localparam logic [4:0] K_STAR     = 5'd24;
    localparam logic [4:0] K_SLASH    = 5'd25;
    localparam logic [4:0] K_COMMA    = 5'd26;
    localparam logic [4:0] K_LBRACKET = 5'd27;
    localparam logic [4:0] K_RBRACKET = 5'd28;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
    } t_token;

    typedef struct packed {
        logic   two;
        t_token tok_a;
        t_token tok_b;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic logic [15:0] span(input logic [15:0] from, input logic [15:0] to);
        return (to >= from) ? (to - from) : 16'd0;
    endfunction

    function automatic logic [2:0] first_guess(input logic [7:0] b);
        logic [2:0] g;
        case (b)
            "f": g = KW_FALSE;
            "i": g = KW_INCLUDE;
            "n": g = KW_NIL;
            "p": g = KW_PRINT;
            "t": g = KW_TRUE;
            default: g = KW_NONE;
        endcase
        return g;
    endfunction

    function automatic logic [2:0] kw_len(input logic [2:0] g);
        logic [2:0] n;
        case (g)
            KW_FALSE:   n = 3'd4;
            KW_INCLUDE: n = 3'd6;
            KW_NIL:     n = 3'd2;
            KW_PRINT:   n = 3'd4;
            KW_TRUE:    n = 3'd3;
            default:    n = 3'd0;
        endcase
        return n;
    endfunction

    // Character k of the keyword tail, counted from its first character.
    function automatic logic [7:0] kw_char(input logic [2:0] g, input logic [2:0] k);
        logic [47:0] tail;
        logic [2:0]  n;
        logic [7:0]  c;
        n = kw_len(g);
        case (g)
            KW_FALSE:   tail = {16'd0, KW_FALSE_TAIL};
            KW_INCLUDE: tail = KW_INCLUDE_TAIL;
            KW_NIL:     tail = {32'd0, KW_NIL_TAIL};
            KW_PRINT:   tail = {16'd0, KW_PRINT_TAIL};
            KW_TRUE:    tail = {24'd0, KW_TRUE_TAIL};
            default:    tail = 48'd0;
        endcase
        if (k < n) begin
            c = 8'(tail >> {(n - 3'd1 - k), 3'b000});
        end else begin
            c = CH_NUL;
        end
        return c;
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] b);
        logic [4:0] k;
        case (b)
            ";": k = K_SEMI;
            "(": k = K_LPAREN;
            ")": k = K_RPAREN;
            ".": k = K_DOT;
            "+": k = K_PLUS;
            "-": k = K_MINUS;
            "*": k = K_STAR;
            "/": k = K_SLASH;
            ",": k = K_COMMA;
            "[": k = K_LBRACKET;
            "]": k = K_RBRACKET;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

endpackage

// File: hw/rtl/source_text_tokenizer_unit.sv
// Channel  Direction  Handshake                    Payload
// source   in         i_src_valid / o_src_ready    i_source_byte
// token    out        o_tok_valid / i_tok_ready    o_token_kind, o_start_offset,
//                                                  o_text_length, o_line_number,
//                                                  o_last_of_run
//
// One source byte is taken per cycle while the token queue has room.
// A token is pushed into the queue when the byte that completes it is taken, then loaded into
// the output register, which sends one token per cycle while i_tok_ready is high.
// A byte that closes one token and starts another puts both tokens in one queue entry.
// Reset is synchronous and active low; it clears the scan state, queue and output valid.
// o_src_ready falls only when the queue is full; a stalled output holds its token.
module source_text_tokenizer_unit #(
    parameter int FIFO_DEPTH = stt_pkg::FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_src_valid,
    output logic        o_src_ready,
    input  logic [7:0]  i_source_byte,
    output logic        o_tok_valid,
    input  logic        i_tok_ready,
    output logic [4:0]  o_token_kind,
    output logic [15:0] o_start_offset,
    output logic [15:0] o_text_length,
    output logic [15:0] o_line_number,
    output logic        o_last_of_run
);

    logic                accept;
    logic                push;
    logic                pop;
    stt_pkg::t_entry     entry;
    stt_pkg::t_entry     head;
    stt_pkg::t_fifo_stat stat;
    stt_pkg::t_token     tok;

    assign o_src_ready = !stat.full;
    assign accept      = i_src_valid && o_src_ready;

    stt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_source_byte (i_source_byte),
        .o_push        (push),
        .o_entry       (entry)
    );

    stt_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (stat)
    );

    stt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_stat  (stat),
        .o_pop   (pop),
        .i_ready (i_tok_ready),
        .o_valid (o_tok_valid),
        .o_tok   (tok),
        .o_last  (o_last_of_run)
    );

    assign o_token_kind   = tok.kind;
    assign o_start_offset = tok.start;
    assign o_text_length  = tok.len;
    assign o_line_number  = tok.line;

endmodule

// File: hw/rtl/stt_front.sv
module stt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_source_byte,
    output logic                o_push,
    output stt_pkg::t_entry     o_entry
);

    localparam logic [3:0] M_IDLE       = 4'd0;
    localparam logic [3:0] M_COMMENT    = 4'd1;
    localparam logic [3:0] M_NUMBER     = 4'd2;
    localparam logic [3:0] M_IDENT      = 4'd3;
    localparam logic [3:0] M_STRING     = 4'd4;
    localparam logic [3:0] M_AFTER_EQ   = 4'd5;
    localparam logic [3:0] M_AFTER_BANG = 4'd6;
    localparam logic [3:0] M_AFTER_LT   = 4'd7;
    localparam logic [3:0] M_AFTER_GT   = 4'd8;

    logic [3:0]  r_mode, n_mode;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_begin, n_begin;
    logic [15:0] r_line, n_line;
    logic [2:0]  r_guess, n_guess;
    logic        r_alive, n_alive;

    logic [7:0]  b;
    logic [15:0] pos_inc;
    logic [15:0] line_inc;

    logic             id_emit;
    stt_pkg::t_token  id_tok;
    logic [3:0]       id_mode;
    logic [15:0]      id_pos;
    logic [15:0]      id_begin;
    logic [15:0]      id_line;
    logic [2:0]       id_guess;
    logic             id_alive;

    logic             a_v;
    logic             b_v;
    stt_pkg::t_token  a_tok;
    logic             to_idle;
    logic             idle_second;
    logic [4:0]       single_kind;
    logic [4:0]       pair_kind;
    logic [15:0]      idx;
    logic             kw_hit;
    logic             kw_done;

    assign b        = i_source_byte;
    assign pos_inc  = (r_pos < stt_pkg::POS_CAP) ? (r_pos + 16'd1) : r_pos;
    assign line_inc = (r_line < stt_pkg::LINE_CAP) ? (r_line + 16'd1) : r_line;
    assign idx      = stt_pkg::span(r_begin, r_pos);

    assign kw_hit = r_alive && (r_guess >= stt_pkg::KW_FALSE) &&
                    (r_guess <= stt_pkg::KW_TRUE) &&
                    (idx >= 16'd1) && (idx <= 16'd6) &&
                    (stt_pkg::kw_char(r_guess, 3'(idx - 16'd1)) == b);
    assign kw_done = r_alive && (r_guess >= stt_pkg::KW_FALSE) &&
                     (r_guess <= stt_pkg::KW_TRUE) &&
                     (idx == {13'd0, stt_pkg::kw_len(r_guess)} + 16'd1);

    always_comb begin
        id_emit   = 1'b0;
        id_tok    = '{kind: stt_pkg::K_ERROR, start: r_pos, len: 16'd1, line: r_line};
        id_mode   = M_IDLE;
        id_pos    = pos_inc;
        id_begin  = r_begin;
        id_line   = r_line;
        id_guess  = r_guess;
        id_alive  = r_alive;
        if (b == stt_pkg::CH_NUL) begin
            id_emit      = 1'b1;
            id_tok.kind  = stt_pkg::K_END;
            id_tok.len   = 16'd0;
            id_pos       = 16'd0;
            id_begin     = 16'd0;
            id_line      = 16'd0;
            id_guess     = stt_pkg::KW_NONE;
            id_alive     = 1'b0;
        end else if (b == stt_pkg::CH_NL) begin
            id_line = line_inc;
        end else if ((b == stt_pkg::CH_SPACE) || (b == stt_pkg::CH_TAB) ||
                     (b == stt_pkg::CH_CR)) begin
            id_mode = M_IDLE;
        end else if (b == stt_pkg::CH_HASH) begin
            id_mode = M_COMMENT;
        end else if (stt_pkg::is_digit(b)) begin
            id_begin = r_pos;
            id_mode  = M_NUMBER;
        end else if (stt_pkg::is_alpha(b) || (b == stt_pkg::CH_US)) begin
            id_begin = r_pos;
            id_mode  = M_IDENT;
            id_guess = stt_pkg::first_guess(b);
            id_alive = (stt_pkg::first_guess(b) != stt_pkg::KW_NONE);
        end else if (b == stt_pkg::CH_QUOTE) begin
            id_mode  = M_STRING;
            id_begin = pos_inc;
        end else if (b == stt_pkg::CH_EQ) begin
            id_begin = r_pos;
            id_mode  = M_AFTER_EQ;
        end else if (b == stt_pkg::CH_BANG) begin
            id_begin = r_pos;
            id_mode  = M_AFTER_BANG;
        end else if (b == stt_pkg::CH_LT) begin
            id_begin = r_pos;
            id_mode  = M_AFTER_LT;
        end else if (b == stt_pkg::CH_GT) begin
            id_begin = r_pos;
            id_mode  = M_AFTER_GT;
        end else begin
            id_emit     = 1'b1;
            id_tok.kind = stt_pkg::punct_kind(b);
        end
    end

    always_comb begin
        case (r_mode)
            M_AFTER_EQ: begin
                single_kind = stt_pkg::K_ASSIGN;
                pair_kind   = stt_pkg::K_EQ_EQ;
            end
            M_AFTER_BANG: begin
                single_kind = stt_pkg::K_BANG;
                pair_kind   = stt_pkg::K_BANG_EQ;
            end
            M_AFTER_LT: begin
                single_kind = stt_pkg::K_LT;
                pair_kind   = stt_pkg::K_LT_EQ;
            end
            M_AFTER_GT: begin
                single_kind = stt_pkg::K_GT;
                pair_kind   = stt_pkg::K_GT_EQ;
            end
            default: begin
                single_kind = stt_pkg::K_ERROR;
                pair_kind   = stt_pkg::K_ERROR;
            end
        endcase
    end

    always_comb begin
        a_v         = 1'b0;
        b_v         = 1'b0;
        a_tok       = '{kind: stt_pkg::K_ERROR, start: r_begin, len: idx, line: r_line};
        to_idle     = 1'b0;
        idle_second = 1'b0;
        n_mode      = r_mode;
        n_pos       = pos_inc;
        n_begin     = r_begin;
        n_line      = r_line;
        n_guess     = r_guess;
        n_alive     = r_alive;
        case (r_mode)
            M_COMMENT: begin
                if ((b == stt_pkg::CH_NL) || (b == stt_pkg::CH_NUL)) begin
                    to_idle = 1'b1;
                end
            end
            M_STRING: begin
                if (b == stt_pkg::CH_QUOTE) begin
                    a_v        = 1'b1;
                    a_tok.kind = stt_pkg::K_STRING;
                    n_mode     = M_IDLE;
                end else if (b == stt_pkg::CH_NUL) begin
                    a_v         = 1'b1;
                    a_tok.kind  = stt_pkg::K_STRING;
                    to_idle     = 1'b1;
                    idle_second = 1'b1;
                end
            end
            M_NUMBER: begin
                if (!stt_pkg::is_digit(b)) begin
                    a_v         = 1'b1;
                    a_tok.kind  = stt_pkg::K_NUMBER;
                    to_idle     = 1'b1;
                    idle_second = 1'b1;
                end
            end
            M_IDENT: begin
                if (stt_pkg::is_alpha(b) || stt_pkg::is_digit(b) ||
                    (b == stt_pkg::CH_US)) begin
                    n_alive = kw_hit;
                end else begin
                    a_v         = 1'b1;
                    a_tok.kind  = kw_done ? (stt_pkg::K_KW_BASE + {2'd0, r_guess}) :
                                            stt_pkg::K_IDENT;
                    to_idle     = 1'b1;
                    idle_second = 1'b1;
                end
            end
            M_AFTER_EQ, M_AFTER_BANG, M_AFTER_LT, M_AFTER_GT: begin
                a_v = 1'b1;
                if (b == stt_pkg::CH_EQ) begin
                    a_tok.kind = pair_kind;
                    a_tok.len  = stt_pkg::span(r_begin, pos_inc);
                    n_mode     = M_IDLE;
                end else begin
                    a_tok.kind  = single_kind;
                    to_idle     = 1'b1;
                    idle_second = 1'b1;
                end
            end
            default: begin
                to_idle = 1'b1;
            end
        endcase
        if (to_idle) begin
            n_mode  = id_mode;
            n_pos   = id_pos;
            n_begin = id_begin;
            n_line  = id_line;
            n_guess = id_guess;
            n_alive = id_alive;
            if (idle_second) begin
                b_v = id_emit;
            end else begin
                a_v   = id_emit;
                a_tok = id_tok;
            end
        end
    end

    assign o_push        = i_accept && a_v;
    assign o_entry.two   = b_v;
    assign o_entry.tok_a = a_tok;
    assign o_entry.tok_b = id_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pos   <= 16'd0;
            r_begin <= 16'd0;
            r_line  <= 16'd0;
            r_guess <= stt_pkg::KW_NONE;
            r_alive <= 1'b0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_begin <= n_begin;
            r_line  <= n_line;
            r_guess <= n_guess;
            r_alive <= n_alive;
        end
    end

`ifndef SYNTHESIS
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_source_byte == stt_pkg::CH_NUL)) |=>
        ((r_pos == 16'd0) && (r_line == 16'd0) && (r_mode == M_IDLE)))
        else $error("End of text did not clear the scan positions.");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_entry.two) |-> (o_entry.tok_a.kind != stt_pkg::K_END))
        else $error("A token follows the end token in one request.");

    a_pos_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= stt_pkg::POS_CAP)
        else $error("Byte position passed its cap.");
`endif

endmodule

// File: hw/rtl/stt_fifo.sv
module stt_fifo #(
    parameter int DEPTH = stt_pkg::FIFO_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  stt_pkg::t_entry      i_entry,
    input  logic                 i_pop,
    output stt_pkg::t_entry      o_head,
    output stt_pkg::t_fifo_stat  o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    stt_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, n_wptr;
    logic [AW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push;
    logic            do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == FULL);
    assign o_head       = r_mem[r_rptr];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == LAST) ? '0 : (r_wptr + AW'(1));
        end
        if (do_pop) begin
            n_rptr = (r_rptr == LAST) ? '0 : (r_rptr + AW'(1));
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= FULL) && (((r_wptr - r_rptr) == AW'(r_count)) ||
        (DEPTH != (1 << AW))))
        else $error("Queue fill count disagrees with its pointers.");
`endif

endmodule

// File: hw/rtl/stt_back.sv
module stt_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  stt_pkg::t_entry      i_head,
    input  stt_pkg::t_fifo_stat  i_stat,
    output logic                 o_pop,
    input  logic                 i_ready,
    output logic                 o_valid,
    output stt_pkg::t_token      o_tok,
    output logic                 o_last
);

    logic            r_valid;
    logic            r_half;
    logic            r_last;
    stt_pkg::t_token r_tok;
    logic            load;
    logic            take;
    logic            head_last;

    assign load      = !r_valid || i_ready;
    assign take      = load && !i_stat.empty;
    assign head_last = !i_head.two || r_half;
    assign o_pop     = take && head_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (load) begin
            r_valid <= !i_stat.empty;
            if (take) begin
                r_half <= !head_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_tok  <= r_half ? i_head.tok_b : i_head.tok_a;
            r_last <= head_last;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;
    assign o_last  = r_last;

`ifndef SYNTHESIS
    a_half_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (r_valid && !r_last && !i_stat.empty))
        else $error("Second token of a request is pending without its first.");
`endif

endmodule
